// ===== sv/hpt_pkg.sv =====
// Shared types and constants for the homogeneous point transform unit.
package hpt_pkg;

    localparam int COORD_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF   = 16;
    localparam int NUM_REGS        = 8;
    localparam int REG_WIDTH       = 64;
    localparam int REG_IDX_WIDTH   = 3;
    localparam int FIELD_WIDTH     = 32;

    typedef struct packed {
        logic [FIELD_WIDTH-1:0] point_x;
        logic [FIELD_WIDTH-1:0] point_y;
        logic [FIELD_WIDTH-1:0] point_z;
    } t_in_item;

    typedef struct packed {
        logic [FIELD_WIDTH-1:0] result_x;
        logic [FIELD_WIDTH-1:0] result_y;
        logic [FIELD_WIDTH-1:0] result_z;
        logic                   was_divided;
        logic                   saturated;
    } t_out_item;

    localparam logic [REG_WIDTH-1:0] REG_RESET [NUM_REGS] = '{
        64'd65536, 64'd0, 64'd281474976710656, 64'd0,
        64'd0, 64'd65536, 64'd0, 64'd281474976710656
    };

endpackage

// ===== sv/homogeneous_point_transform_unit.sv =====
// Top level of the homogeneous 4x4 point transform with perspective divide.
//
// Items enter on start with i_in; start is taken whenever busy is low,
// and busy stays low, so one point may enter in every cycle.
// Each result appears on o_out for one cycle, marked by o_done; the receiver
// cannot stall and results are never held back.
// The row cells register the products and then the row sums; the next stage
// registers the saturated sums, then a chain of restoring-division cells
// settles one quotient bit per cell, and a last register applies sign and
// clamp. Throughput is one point per cycle.
// The matrix is to be written through i_cfg_we/i_cfg_idx/i_cfg_data only while idle;
// the block itself does not enforce this. Reset loads REG_RESET and clears all valid flags in the chain.
module homogeneous_point_transform_unit import hpt_pkg::*; #(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     start,
    output logic                     busy,
    input  t_in_item                 i_in,
    output logic                     o_done,
    output t_out_item                o_out,
    input  logic                     i_cfg_we,
    input  logic [REG_IDX_WIDTH-1:0] i_cfg_idx,
    input  logic [REG_WIDTH-1:0]     i_cfg_data
);

    localparam int CW    = COORD_WIDTH;
    localparam int NUM_W = CW + FRAC_BITS;
    localparam int PASS_W = 3 * 1 + 2;
    localparam int NC    = 3;
    localparam logic [CW:0] ONE_FULL = (CW+1)'(1) << FRAC_BITS;

    logic [REG_WIDTH-1:0] r_regs [NUM_REGS];
    logic [2:0] r_vld;

    assign busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_REGS; i++) r_regs[i] <= REG_RESET[i];
            r_vld <= '0;
        end else begin
            if (i_cfg_we) r_regs[i_cfg_idx] <= i_cfg_data;
            r_vld <= {r_vld[1:0], start};
        end
    end

    logic [CW-1:0] w_sum [4];
    logic [3:0]    w_sat;

    for (genvar r = 0; r < 4; r++) begin : g_row
        hpt_row_cell #(.COORD_WIDTH(CW), .FRAC_BITS(FRAC_BITS)) u_row (
            .i_clk (i_clk),
            .i_x   (i_in.point_x[CW-1:0]),
            .i_y   (i_in.point_y[CW-1:0]),
            .i_z   (i_in.point_z[CW-1:0]),
            .i_m0  (r_regs[2*r][CW-1:0]),
            .i_m1  (r_regs[2*r][32+CW-1:32]),
            .i_m2  (r_regs[2*r+1][CW-1:0]),
            .i_m3  (r_regs[2*r+1][32+CW-1:32]),
            .o_sum (w_sum[r]),
            .o_sat (w_sat[r])
        );
    end

    // Stage after the rows: decide on division, set up magnitudes.
    logic [CW-1:0] r_s [3];
    logic [CW-1:0] r_wm;
    logic [2:0]    r_ng;
    logic          r_div, r_sat0;

    logic [CW:0]   w_w;
    always_comb w_w = (CW+1)'($signed(w_sum[3]));

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r_s[i]  <= w_sum[i];
            r_ng[i] <= w_sum[i][CW-1] ^ w_sum[3][CW-1];
        end
        r_wm   <= w_sum[3][CW-1] ? CW'(-w_sum[3]) : w_sum[3];
        r_div  <= (w_sum[3] != '0) && (w_w != ONE_FULL);
        r_sat0 <= |w_sat;
    end

    // Division chains: one cell per quotient bit, three lanes side by side.
    logic             c_vld  [NC][NUM_W+1];
    logic [NUM_W-1:0] c_num  [NC][NUM_W+1];
    logic [CW-1:0]    c_den  [NC][NUM_W+1];
    logic [NUM_W-1:0] c_quo  [NC][NUM_W+1];
    logic [CW:0]      c_rem  [NC][NUM_W+1];
    logic [PASS_W-1:0] c_pass [NC][NUM_W+1];

    for (genvar l = 0; l < NC; l++) begin : g_lane
        logic [CW-1:0] w_mg;
        assign w_mg = r_s[l][CW-1] ? CW'(-r_s[l]) : r_s[l];
        assign c_vld[l][0]  = r_vld[2];
        assign c_num[l][0]  = {w_mg, {FRAC_BITS{1'b0}}};
        assign c_den[l][0]  = r_div ? r_wm : CW'(1);
        assign c_quo[l][0]  = '0;
        assign c_rem[l][0]  = '0;
        assign c_pass[l][0] = {r_s[l][CW-1], r_ng[l], r_div, r_sat0, 1'b0};
        for (genvar b = 0; b < NUM_W; b++) begin : g_bit
            hpt_div_cell #(.NUM_W(NUM_W), .DEN_W(CW), .BIT(NUM_W-1-b),
                           .PASS_W(PASS_W)) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_valid (c_vld[l][b]),
                .i_num   (c_num[l][b]),
                .i_den   (c_den[l][b]),
                .i_quo   (c_quo[l][b]),
                .i_rem   (c_rem[l][b]),
                .i_pass  (c_pass[l][b]),
                .o_valid (c_vld[l][b+1]),
                .o_num   (c_num[l][b+1]),
                .o_den   (c_den[l][b+1]),
                .o_quo   (c_quo[l][b+1]),
                .o_rem   (c_rem[l][b+1]),
                .o_pass  (c_pass[l][b+1])
            );
        end
    end

    // Undivided results go through the same chain: the numerator is shifted
    // by FRAC_BITS and divided by one, so recover the sum from the quotient
    // by dropping the fraction shift.
    logic [CW-1:0] n_res [3];
    logic          n_sat;
    logic          r_done;
    t_out_item     r_out;

    always_comb begin
        logic [NUM_W-1:0] q;
        logic [NUM_W:0]   lim;
        logic             ng, dv, sg;
        n_sat = c_pass[0][NUM_W][1];
        for (int l = 0; l < 3; l++) begin
            sg = c_pass[l][NUM_W][4];
            ng = c_pass[l][NUM_W][3];
            dv = c_pass[l][NUM_W][2];
            q  = dv ? c_quo[l][NUM_W] : (c_quo[l][NUM_W] >> FRAC_BITS);
            if (!dv) ng = sg;
            lim = ng ? (NUM_W+1)'(1) << (CW-1) : ((NUM_W+1)'(1) << (CW-1)) - 1'b1;
            if ({1'b0, q} > lim) begin
                n_res[l] = ng ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
                n_sat = 1'b1;
            end else begin
                n_res[l] = ng ? CW'(-q) : q[CW-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= c_vld[0][NUM_W];
        end
        r_out.result_x    <= FIELD_WIDTH'($signed(n_res[0]));
        r_out.result_y    <= FIELD_WIDTH'($signed(n_res[1]));
        r_out.result_z    <= FIELD_WIDTH'($signed(n_res[2]));
        r_out.was_divided <= c_pass[0][NUM_W][2];
        r_out.saturated   <= n_sat;
    end

    assign o_done = r_done;
    assign o_out  = r_out;

endmodule

// ===== sv/hpt_div_cell.sv =====
// One restoring-division cell: settles one quotient bit and hands on the partial remainder.
module hpt_div_cell import hpt_pkg::*; #(
    parameter int NUM_W = 56,
    parameter int DEN_W = 32,
    parameter int BIT   = 0,
    parameter int PASS_W = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [NUM_W-1:0]  i_num,
    input  logic [DEN_W-1:0]  i_den,
    input  logic [NUM_W-1:0]  i_quo,
    input  logic [DEN_W:0]    i_rem,
    input  logic [PASS_W-1:0] i_pass,
    output logic              o_valid,
    output logic [NUM_W-1:0]  o_num,
    output logic [DEN_W-1:0]  o_den,
    output logic [NUM_W-1:0]  o_quo,
    output logic [DEN_W:0]    o_rem,
    output logic [PASS_W-1:0] o_pass
);

    logic [DEN_W+1:0] w_trial;
    logic [DEN_W:0]   n_rem;
    logic             n_bit;
    logic [NUM_W-1:0] n_quo;

    always_comb begin
        w_trial = {i_rem, i_num[BIT]};
        if (w_trial >= {1'b0, 1'b0, i_den}) begin
            n_bit = 1'b1;
            n_rem = DEN_W'(w_trial - {2'b00, i_den}) == '0 ? '0
                  : (DEN_W+1)'(w_trial - {2'b00, i_den});
        end else begin
            n_bit = 1'b0;
            n_rem = (DEN_W+1)'(w_trial);
        end
        n_quo      = i_quo;
        n_quo[BIT] = n_bit;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= i_valid;
        end
        o_num  <= i_num;
        o_den  <= i_den;
        o_rem  <= n_rem;
        o_pass <= i_pass;
        o_quo  <= n_quo;
    end

endmodule

// ===== sv/hpt_row_cell.sv =====
// Matrix row cell: three products, a sum with the offset column, and saturation.
module hpt_row_cell import hpt_pkg::*; #(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic [COORD_WIDTH-1:0] i_x,
    input  logic [COORD_WIDTH-1:0] i_y,
    input  logic [COORD_WIDTH-1:0] i_z,
    input  logic [COORD_WIDTH-1:0] i_m0,
    input  logic [COORD_WIDTH-1:0] i_m1,
    input  logic [COORD_WIDTH-1:0] i_m2,
    input  logic [COORD_WIDTH-1:0] i_m3,
    output logic [COORD_WIDTH-1:0] o_sum,
    output logic                   o_sat
);

    localparam int PW = 2 * COORD_WIDTH;
    localparam int SW = PW + 3;

    logic [PW-1:0] r_p0, r_p1, r_p2;
    logic [2:0]    r_neg;
    logic [COORD_WIDTH-1:0] r_m3;
    logic [SW-1:0] r_acc;

    function automatic logic [COORD_WIDTH-1:0] mag(input logic [COORD_WIDTH-1:0] v);
        return v[COORD_WIDTH-1] ? COORD_WIDTH'(-v) : v;
    endfunction

    function automatic logic signed [SW-1:0] sterm(input logic [PW-1:0] p, input logic ng);
        logic signed [SW-1:0] t;
        t = $signed({3'b000, (p >> FRAC_BITS)});
        return ng ? -t : t;
    endfunction

    logic signed [SW-1:0] n_acc;
    logic signed [SW-1:0] w_hi, w_lo;

    always_ff @(posedge i_clk) begin
        r_p0  <= PW'(mag(i_x)) * PW'(mag(i_m0));
        r_p1  <= PW'(mag(i_y)) * PW'(mag(i_m1));
        r_p2  <= PW'(mag(i_z)) * PW'(mag(i_m2));
        r_neg <= {i_z[COORD_WIDTH-1] ^ i_m2[COORD_WIDTH-1],
                  i_y[COORD_WIDTH-1] ^ i_m1[COORD_WIDTH-1],
                  i_x[COORD_WIDTH-1] ^ i_m0[COORD_WIDTH-1]};
        r_m3  <= i_m3;
    end

    always_comb begin
        n_acc = sterm(r_p0, r_neg[0]) + sterm(r_p1, r_neg[1]) + sterm(r_p2, r_neg[2])
              + SW'($signed(r_m3));
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
    end

    always_comb begin
        w_hi = SW'($signed({1'b0, {(COORD_WIDTH-1){1'b1}}}));
        w_lo = SW'($signed({1'b1, {(COORD_WIDTH-1){1'b0}}}));
        o_sat = 1'b0;
        o_sum = r_acc[COORD_WIDTH-1:0];
        if ($signed(r_acc) > w_hi) begin
            o_sat = 1'b1;
            o_sum = w_hi[COORD_WIDTH-1:0];
        end else if ($signed(r_acc) < w_lo) begin
            o_sat = 1'b1;
            o_sum = w_lo[COORD_WIDTH-1:0];
        end
    end

endmodule

// ===== verif/homogeneous_point_transform_unit_tb.sv =====
// Self-checking testbench for the homogeneous point transform unit.
module homogeneous_point_transform_unit_tb;
    import hpt_pkg::*;

    localparam int CW        = COORD_WIDTH_DEF;
    localparam int FB        = FRAC_BITS_DEF;
    localparam int LATENCY   = CW + FB + 4;
    localparam int MAX_CYCLE = 2000000;
    localparam int N_RANDOM  = 1400;

    localparam logic [REG_IDX_WIDTH-1:0] IDX_R0_C01 = 3'd0;
    localparam logic [REG_IDX_WIDTH-1:0] IDX_R0_C23 = 3'd1;
    localparam logic [REG_IDX_WIDTH-1:0] IDX_R1_C01 = 3'd2;
    localparam logic [REG_IDX_WIDTH-1:0] IDX_R1_C23 = 3'd3;
    localparam logic [REG_IDX_WIDTH-1:0] IDX_R2_C01 = 3'd4;
    localparam logic [REG_IDX_WIDTH-1:0] IDX_R2_C23 = 3'd5;
    localparam logic [REG_IDX_WIDTH-1:0] IDX_R3_C01 = 3'd6;
    localparam logic [REG_IDX_WIDTH-1:0] IDX_R3_C23 = 3'd7;

    localparam logic [31:0] FX_ONE = 32'h0001_0000;
    localparam logic [31:0] FX_MAX = 32'h7fff_ffff;
    localparam logic [31:0] FX_MIN = 32'h8000_0000;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     start;
    logic                     busy;
    t_in_item                 i_in;
    logic                     o_done;
    t_out_item                o_out;
    logic                     i_cfg_we;
    logic [REG_IDX_WIDTH-1:0] i_cfg_idx;
    logic [REG_WIDTH-1:0]     i_cfg_data;

    logic [REG_WIDTH-1:0] matrix_regs [NUM_REGS];
    t_out_item            pending_points [$];
    int                   mismatches;
    int                   cycle_count;
    int                   points_sent;
    int                   points_checked;
    int                   divided_seen;
    int                   saturated_seen;

    homogeneous_point_transform_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_in       (i_in),
        .o_done     (o_done),
        .o_out      (o_out),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic logic signed [63:0] clamp_coord(input logic signed [63:0] v,
                                                       inout logic flag);
        logic signed [63:0] hi;
        logic signed [63:0] lo;
        hi = (64'sd1 <<< (CW - 1)) - 1;
        lo = -(64'sd1 <<< (CW - 1));
        if (v > hi) begin
            flag = 1'b1;
            return hi;
        end
        if (v < lo) begin
            flag = 1'b1;
            return lo;
        end
        return v;
    endfunction

    function automatic logic signed [63:0] matrix_entry(input int r, input int c);
        logic [REG_WIDTH-1:0] reg_val;
        logic [31:0]          half;
        reg_val = matrix_regs[r * 2 + c / 2];
        half    = (c % 2) ? reg_val[63:32] : reg_val[31:0];
        return 64'(signed'(half[CW-1:0]));
    endfunction

    function automatic logic [63:0] magnitude(input logic signed [63:0] v);
        return v < 0 ? 64'(-v) : 64'(v);
    endfunction

    function automatic logic signed [63:0] fx_mul(input logic signed [63:0] a,
                                                  input logic signed [63:0] b);
        logic [63:0] p;
        p = (magnitude(a) * magnitude(b)) >> FB;
        return ((a < 0) != (b < 0)) ? -$signed(p) : $signed(p);
    endfunction

    function automatic logic signed [63:0] fx_div(input logic signed [63:0] n,
                                                  input logic signed [63:0] d);
        logic [63:0] q;
        q = (magnitude(n) << FB) / magnitude(d);
        return ((n < 0) != (d < 0)) ? -$signed(q) : $signed(q);
    endfunction

    function automatic t_out_item transform_point(input t_in_item pt);
        logic signed [63:0] coord [3];
        logic signed [63:0] sum [4];
        logic signed [63:0] acc;
        logic               flag;
        logic               divided;
        t_out_item          res;
        flag    = 1'b0;
        divided = 1'b0;
        coord[0] = 64'(signed'(pt.point_x[CW-1:0]));
        coord[1] = 64'(signed'(pt.point_y[CW-1:0]));
        coord[2] = 64'(signed'(pt.point_z[CW-1:0]));
        for (int r = 0; r < 4; r++) begin
            acc = fx_mul(coord[0], matrix_entry(r, 0)) + fx_mul(coord[1], matrix_entry(r, 1))
                + fx_mul(coord[2], matrix_entry(r, 2)) + matrix_entry(r, 3);
            sum[r] = clamp_coord(acc, flag);
        end
        if (sum[3] != 0 && sum[3] != (64'sd1 <<< FB)) begin
            divided = 1'b1;
            for (int i = 0; i < 3; i++)
                sum[i] = clamp_coord(fx_div(sum[i], sum[3]), flag);
        end
        res.result_x    = sum[0][31:0];
        res.result_y    = sum[1][31:0];
        res.result_z    = sum[2][31:0];
        res.was_divided = divided;
        res.saturated   = flag;
        return res;
    endfunction

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= MAX_CYCLE) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Simulation FAILED");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        t_out_item exp_pt;
        if (i_rst_n && o_done) begin
            if (pending_points.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected result %h", o_out);
            end else begin
                exp_pt = pending_points.pop_front();
                points_checked++;
                if (exp_pt.was_divided) divided_seen++;
                if (exp_pt.saturated) saturated_seen++;
                if (o_out.result_x !== exp_pt.result_x || o_out.result_y !== exp_pt.result_y
                    || o_out.result_z !== exp_pt.result_z
                    || o_out.was_divided !== exp_pt.was_divided
                    || o_out.saturated !== exp_pt.saturated) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"Mismatch: expected x=%h y=%h z=%h div=%b sat=%b, ",
                                  "got x=%h y=%h z=%h div=%b sat=%b"},
                            exp_pt.result_x, exp_pt.result_y, exp_pt.result_z,
                            exp_pt.was_divided, exp_pt.saturated,
                            o_out.result_x, o_out.result_y, o_out.result_z,
                            o_out.was_divided, o_out.saturated);
                end
            end
        end
    end

    function automatic int idle_gap();
        if ($urandom_range(0, 2) == 0) return 0;
        if ($urandom_range(0, 19) == 0) return $urandom_range(10, 60);
        return $urandom_range(0, 3);
    endfunction

    task automatic send_point(input t_in_item pt, input int gap);
        start <= 1'b1;
        i_in  <= pt;
        do @(posedge i_clk); while (busy);
        pending_points.push_back(transform_point(pt));
        points_sent++;
        if (gap > 0) begin
            start <= 1'b0;
            i_in  <= t_in_item'({$urandom, $urandom, $urandom});
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic end_burst();
        start <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic drain();
        end_burst();
        while (pending_points.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Leaves the write enable high; the caller drops it after the last write.
    task automatic write_reg(input logic [REG_IDX_WIDTH-1:0] idx, input logic [63:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        matrix_regs[idx] = val;
    endtask

    task automatic write_matrix(input logic [63:0] vals [NUM_REGS]);
        for (int i = 0; i < NUM_REGS; i++)
            write_reg(REG_IDX_WIDTH'(i), vals[i]);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 7))
            0: return FX_MAX;
            1: return FX_MIN;
            2: return 32'(signed'($urandom_range(0, 2048)) - 1024);
            3: return 32'(signed'($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [63:0] rand_row_pair();
        return {rand_coord(), rand_coord()};
    endfunction

    task automatic test_identity_directed();
        t_in_item pt;
        logic [31:0] corner [6];
        corner = '{32'h0, FX_ONE, FX_MAX, FX_MIN, 32'hffff_ffff, 32'h0001_8000};
        for (int i = 0; i < 6; i++) begin
            pt = '{corner[i], corner[(i + 2) % 6], corner[(i + 4) % 6]};
            send_point(pt, 0);
        end
        drain();
    endtask

    task automatic test_perspective_directed();
        logic [63:0] vals [NUM_REGS];
        vals = REG_RESET;
        // w = z gives a true perspective divide
        vals[IDX_R3_C01] = 64'h0;
        vals[IDX_R3_C23] = {32'h0, FX_ONE};
        write_matrix(vals);
        send_point('{FX_ONE, FX_ONE, 32'h0002_0000}, 0);
        send_point('{32'h0, 32'h0, 32'h0}, 0);
        send_point('{FX_MAX, FX_MIN, FX_ONE}, 0);
        send_point('{FX_MAX, FX_MIN, 32'h0000_0001}, 0);
        send_point('{FX_MIN, FX_MAX, 32'hffff_ffff}, 0);
        send_point('{32'h0003_0000, 32'hfffd_0000, FX_MIN}, 1);
        send_point('{32'h0003_0000, 32'hfffd_0000, FX_MAX}, 0);
        drain();
        // clamped w and overflowing sums
        vals = '{{FX_MAX, FX_MAX}, {FX_MAX, FX_MAX}, {FX_MIN, FX_MIN}, {FX_MIN, FX_MIN},
                 {FX_MAX, FX_MIN}, {FX_MAX, 32'h0}, {FX_MAX, FX_MAX}, {FX_MAX, FX_MAX}};
        write_matrix(vals);
        send_point('{FX_MAX, FX_MAX, FX_MAX}, 0);
        send_point('{FX_MIN, FX_MIN, FX_MIN}, 0);
        send_point('{32'h0, 32'h0, 32'h0}, 0);
        send_point('{FX_ONE, 32'h0, 32'h0}, 0);
        drain();
        // zero matrix: w = 0, no divide
        vals = '{default: 64'h0};
        write_matrix(vals);
        send_point('{FX_MAX, FX_MIN, FX_ONE}, 0);
        drain();
    endtask

    task automatic test_random_matrices();
        logic [63:0] vals [NUM_REGS];
        t_in_item pt;
        int per_phase;
        per_phase = N_RANDOM / 7;
        for (int ph = 0; ph < 7; ph++) begin
            for (int i = 0; i < NUM_REGS; i++) vals[i] = rand_row_pair();
            if (ph % 3 == 0) begin
                // keep w near one so that the divide is common
                vals[IDX_R3_C01] = {32'(signed'($urandom_range(0, 64)) - 32),
                                    32'(signed'($urandom_range(0, 64)) - 32)};
                vals[IDX_R3_C23] = {FX_ONE + 32'($urandom_range(0, 8)),
                                    32'($urandom_range(0, 8))};
            end
            if (ph == 6) vals = REG_RESET;
            write_matrix(vals);
            for (int n = 0; n < per_phase; n++) begin
                pt = '{rand_coord(), rand_coord(), rand_coord()};
                send_point(pt, (ph == 2) ? 0 : idle_gap());
                if (n == per_phase / 2) begin
                    end_burst();
                    while (pending_points.size() != 0) @(posedge i_clk);
                end
            end
            drain();
        end
    endtask

    task automatic test_bad_index();
        // only 8 registers exist, so every index is valid: rewrite all of them and check
        write_reg(IDX_R0_C01, {32'h0, FX_ONE});
        write_reg(IDX_R0_C23, 64'h0);
        write_reg(IDX_R1_C01, {FX_ONE, 32'h0});
        write_reg(IDX_R1_C23, 64'h0);
        write_reg(IDX_R2_C01, 64'h0);
        write_reg(IDX_R2_C23, {32'h0, FX_ONE});
        write_reg(IDX_R3_C01, 64'h0);
        write_reg(IDX_R3_C23, {FX_ONE, 32'h0});
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        send_point('{32'h1234_5678, 32'h8765_4321, 32'hdead_beef}, 0);
        drain();
    endtask

    initial begin
        i_clk       = 1'b0;
        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_in        = '0;
        i_cfg_we    = 1'b0;
        i_cfg_idx   = '0;
        i_cfg_data  = '0;
        mismatches  = 0;
        cycle_count = 0;
        points_sent = 0;
        points_checked = 0;
        divided_seen   = 0;
        saturated_seen = 0;
        matrix_regs = REG_RESET;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_identity_directed();
        test_perspective_directed();
        test_random_matrices();
        test_bad_index();

        repeat (LATENCY + 8) @(posedge i_clk);
        if (pending_points.size() != 0) begin
            mismatches++;
            $display("%0d results never arrived", pending_points.size());
        end
        $display("Sent %0d points, checked %0d (%0d divided, %0d saturated) over %0d cycles",
                 points_sent, points_checked, divided_seen, saturated_seen, cycle_count);
        if (mismatches == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
